// File: rtl/tasc_pkg.sv
// ----------------------------------------------------------------------------
// Two-axis servo controller package
// Shared widths, limits, codes, per-axis bundles and helper functions.
// ----------------------------------------------------------------------------
package tasc_pkg;

	localparam int ANGLE_W  = 18;
	localparam int VALUE_W  = 21;
	localparam int TIME_W   = 32;
	localparam int HOLD_W   = 16;
	localparam int PERIOD_W = 10;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int SLEW_W   = 15;

	localparam int ANGLE_LIMIT = 90000;
	localparam int VEL_LIMIT   = 1000000;
	localparam int SLEW_PER_MS = 30;
	localparam int SNAP_MDEG   = 10;
	localparam int MAX_DT_MS   = 1000;
	localparam logic [PERIOD_W-1:0] FALLBACK_DT_MS = PERIOD_W'(10);

	// velocity * dt product and the divide-by-1000 reciprocal
	localparam int PROD_W      = 31;
	localparam int MAG_W       = PROD_W - 1;
	localparam int RECIP_W     = 31;
	localparam int RECIP_SHIFT = 40;
	localparam int QUOT_W      = MAG_W + RECIP_W;
	localparam int STEP_W      = QUOT_W - RECIP_SHIFT;
	localparam logic [RECIP_W-1:0] RECIP_1000 = RECIP_W'(64'd1099511628);

	localparam logic [CFG_W-1:0] SILENT_RESET = 16'd100;
	localparam logic [CFG_W-1:0] SLEEP_RESET = 16'd5000;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd10;

	localparam logic [CFG_IDX_W-1:0] CFG_SILENT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLEEP  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd2;

	typedef enum logic [1:0] {
		CMD_TICK           = 2'd0,
		CMD_SET_ANGLES     = 2'd1,
		CMD_SET_VELOCITIES = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_IDLE     = 2'd0,
		MODE_TARGET   = 2'd1,
		MODE_VELOCITY = 2'd2
	} mode_t;

	typedef logic signed [ANGLE_W-1:0] angle_t;
	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [TIME_W-1:0]         stamp_t;

	// per-axis operation decoded from one transaction
	typedef struct packed {
		logic   tick;
		logic   cancel_vel;
		logic   set_angle;
		logic   set_vel;
		value_t value;
	} axis_op_t;

	// shared timing and configuration seen by both axes
	typedef struct packed {
		stamp_t                clock_now;
		stamp_t                clock_tick;
		stamp_t                deadline_new;
		logic                  silent_zero;
		logic [CFG_W-1:0]      sleep_lim;
		logic [SLEW_W-1:0]     slew_lim;
		logic [PERIOD_W-1:0]   dt_next;
	} axis_env_t;

	typedef struct packed {
		angle_t angle;
		logic   attached;
		logic   write;
		logic   detach;
	} axis_res_t;

	// motion step period: out-of-range periods fall back to 10 ms
	function automatic logic [PERIOD_W-1:0] dt_of(input logic [PERIOD_W-1:0] period);
		logic [PERIOD_W-1:0] dt;
		dt = period;
		if (period == '0 || int'(period) > MAX_DT_MS) begin
			dt = FALLBACK_DT_MS;
		end
		return dt;
	endfunction

	function automatic logic [SLEW_W-1:0] slew_of(input logic [PERIOD_W-1:0] dt);
		logic [SLEW_W-1:0] lim;
		lim = SLEW_W'(dt) * SLEW_W'(SLEW_PER_MS);
		return lim;
	endfunction

endpackage

// File: rtl/two_axis_servo_motion_controller.sv
// ----------------------------------------------------------------------------
// Two-axis servo motion controller
// Pipeline: a transaction lands in the input register when it is accepted;
//   its result is loaded into the result register when that register is empty
//   or being drained, and is presented there until out_ready takes it.
// Throughput: one transaction per cycle while out_ready does not stall; the output register lets the next
//   transaction enter while a finished result still waits for out_ready.
// Reset: arst_n clears the clock, both axes (attached, idle, at zero) and
//   loads the configuration defaults 100 / 5000 / 10.
// ----------------------------------------------------------------------------
module two_axis_servo_motion_controller (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write port
	input  logic                                 cfg_write,
	input  logic [tasc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tasc_pkg::CFG_W-1:0]           cfg_data,
	// command channel
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           command,
	input  logic                                 yaw_valid,
	input  logic                                 pitch_valid,
	input  logic signed [tasc_pkg::VALUE_W-1:0]  yaw_value,
	input  logic signed [tasc_pkg::VALUE_W-1:0]  pitch_value,
	input  logic [tasc_pkg::HOLD_W-1:0]          hold_ms,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [tasc_pkg::ANGLE_W-1:0]  yaw_angle,
	output logic signed [tasc_pkg::ANGLE_W-1:0]  pitch_angle,
	output logic                                 yaw_attached,
	output logic                                 pitch_attached,
	output logic                                 yaw_write,
	output logic                                 pitch_write,
	output logic                                 yaw_detach,
	output logic                                 pitch_detach
);
	import tasc_pkg::*;

	// configuration registers
	logic [CFG_W-1:0]    silent_q;
	logic [CFG_W-1:0]    sleep_q;
	logic [PERIOD_W-1:0] period_q;
	logic [PERIOD_W-1:0] period_next;
	logic [PERIOD_W-1:0] dt_eff;

	// input stage
	logic                valid_s1;
	logic [1:0]          cmd_s1;
	logic                yaw_given_s1, pitch_given_s1;
	value_t              yaw_value_s1, pitch_value_s1;
	logic [HOLD_W-1:0]   hold_s1;

	// millisecond clock
	stamp_t              clock_q;

	logic                advance;
	logic                is_tick, angles_ok, vel_ok;
	logic                yaw_in_range, pitch_in_range;
	axis_op_t            yaw_op, pitch_op;
	axis_env_t           env;
	axis_res_t           yaw_res, pitch_res;

	// output register
	logic                out_valid_q;
	axis_res_t           yaw_res_q, pitch_res_q;

	// A transaction in the input stage moves on whenever the output register
	// is empty or being drained this cycle.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Config writes: unknown indexes drop silently. The period seen next
	// cycle is looked ahead so the cached velocity product never goes stale.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			silent_q <= SILENT_RESET;
			sleep_q  <= SLEEP_RESET;
			period_q <= PERIOD_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_SILENT: silent_q <= cfg_data;
				CFG_SLEEP:  sleep_q  <= cfg_data;
				CFG_PERIOD: period_q <= cfg_data[PERIOD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign period_next = (cfg_write && cfg_index == CFG_PERIOD) ?
		cfg_data[PERIOD_W-1:0] : period_q;
	assign dt_eff = dt_of(period_q);

	// Capture the transaction; payload needs no reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1         <= command;
			yaw_given_s1   <= yaw_valid;
			pitch_given_s1 <= pitch_valid;
			yaw_value_s1   <= yaw_value;
			pitch_value_s1 <= pitch_value;
			hold_s1        <= hold_ms;
		end
	end

	// Decode. A set-angles transaction needs at least one angle and every
	// given angle in range; set-velocities needs both values in range.
	// Command code 3 decodes to nothing and just reports the state.
	assign yaw_in_range   = yaw_value_s1 >= -ANGLE_LIMIT && yaw_value_s1 <= ANGLE_LIMIT;
	assign pitch_in_range = pitch_value_s1 >= -ANGLE_LIMIT &&
		pitch_value_s1 <= ANGLE_LIMIT;

	assign is_tick   = cmd_s1 == CMD_TICK;
	assign angles_ok = cmd_s1 == CMD_SET_ANGLES && (yaw_given_s1 || pitch_given_s1) &&
		(!yaw_given_s1 || yaw_in_range) && (!pitch_given_s1 || pitch_in_range);
	assign vel_ok    = cmd_s1 == CMD_SET_VELOCITIES &&
		yaw_value_s1 >= -VEL_LIMIT && yaw_value_s1 <= VEL_LIMIT &&
		pitch_value_s1 >= -VEL_LIMIT && pitch_value_s1 <= VEL_LIMIT;

	always_comb begin
		yaw_op.tick        = advance && is_tick;
		yaw_op.cancel_vel  = advance && angles_ok;
		yaw_op.set_angle   = yaw_given_s1;
		yaw_op.set_vel     = advance && vel_ok;
		yaw_op.value       = yaw_value_s1;
		pitch_op.tick      = advance && is_tick;
		pitch_op.cancel_vel = advance && angles_ok;
		pitch_op.set_angle = pitch_given_s1;
		pitch_op.set_vel   = advance && vel_ok;
		pitch_op.value     = pitch_value_s1;
	end

	// Shared timing: the tick advances the clock by the raw period, motion
	// uses the sanitized period.
	always_comb begin
		env.clock_now    = clock_q;
		env.clock_tick   = clock_q + TIME_W'(period_q);
		env.deadline_new = clock_q + TIME_W'(hold_s1);
		env.silent_zero  = silent_q == '0;
		env.sleep_lim    = sleep_q;
		env.slew_lim     = slew_of(dt_eff);
		env.dt_next      = dt_of(period_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= '0;
		end else if (advance && is_tick) begin
			clock_q <= env.clock_tick;
		end
	end

	tasc_axis u_yaw (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.op     (yaw_op),
		.env    (env),
		.res    (yaw_res)
	);

	tasc_axis u_pitch (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.op     (pitch_op),
		.env    (env),
		.res    (pitch_res)
	);

	// Result register: fill on advance, drop the valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			yaw_res_q   <= yaw_res;
			pitch_res_q <= pitch_res;
		end
	end

	assign out_valid      = out_valid_q;
	assign yaw_angle      = yaw_res_q.angle;
	assign pitch_angle    = pitch_res_q.angle;
	assign yaw_attached   = yaw_res_q.attached;
	assign pitch_attached = pitch_res_q.attached;
	assign yaw_write      = yaw_res_q.write;
	assign pitch_write    = pitch_res_q.write;
	assign yaw_detach     = yaw_res_q.detach;
	assign pitch_detach   = pitch_res_q.detach;

endmodule

// File: rtl/tasc_axis.sv
// ----------------------------------------------------------------------------
// Servo axis
// State of one axis and its next-state logic for tick, set-angle and
// set-velocity transactions.
// ----------------------------------------------------------------------------
module tasc_axis (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  tasc_pkg::axis_op_t  op,
	input  tasc_pkg::axis_env_t env,
	output tasc_pkg::axis_res_t res
);
	import tasc_pkg::*;

	angle_t                    angle_q, target_q;
	value_t                    vel_q;
	stamp_t                    deadline_q, last_q;
	logic                      att_q;
	mode_t                     mode_q;
	logic signed [PROD_W-1:0]  prod_q;

	angle_t                    n_angle, n_target;
	value_t                    n_vel, vel_src;
	stamp_t                    n_deadline, n_last;
	logic                      n_att, wr, det;
	mode_t                     n_mode;
	logic signed [PROD_W-1:0]  prod_d;

	logic [MAG_W-1:0]          prod_mag;
	logic [QUOT_W-1:0]         quot_full;
	logic signed [STEP_W:0]    step_s, step;
	logic signed [STEP_W+1:0]  sum;
	angle_t                    vel_next;
	stamp_t                    expire_diff, idle_time;
	logic signed [ANGLE_W:0]   diff, diff_snap;
	logic [ANGLE_W:0]          ad, ad_snap;
	angle_t                    slew_next;

	// velocity step: prod_q holds velocity * dt, divide by 1000 toward zero
	assign prod_mag  = MAG_W'(prod_q[PROD_W-1] ? -prod_q : prod_q);
	assign quot_full = QUOT_W'(prod_mag) * QUOT_W'(RECIP_1000);
	assign step_s    = {1'b0, quot_full[RECIP_SHIFT +: STEP_W]};
	assign step      = prod_q[PROD_W-1] ? -step_s : step_s;
	assign sum       = (STEP_W+2)'(angle_q) + (STEP_W+2)'(step);

	always_comb begin
		if (sum < -ANGLE_LIMIT) begin
			vel_next = ANGLE_W'(-ANGLE_LIMIT);
		end else if (sum > ANGLE_LIMIT) begin
			vel_next = ANGLE_W'(ANGLE_LIMIT);
		end else begin
			vel_next = ANGLE_W'(sum);
		end
	end

	// slew toward target, limited per tick unless motion is instant
	assign diff = (ANGLE_W+1)'(target_q) - (ANGLE_W+1)'(angle_q);
	assign ad   = (ANGLE_W+1)'(diff[ANGLE_W] ? -diff : diff);

	always_comb begin
		slew_next = target_q;
		if (!env.silent_zero && ad > (ANGLE_W+1)'(env.slew_lim)) begin
			if (diff[ANGLE_W]) begin
				slew_next = ANGLE_W'(angle_q - ANGLE_W'(env.slew_lim));
			end else begin
				slew_next = ANGLE_W'(angle_q + ANGLE_W'(env.slew_lim));
			end
		end
	end

	assign diff_snap   = (ANGLE_W+1)'(target_q) - (ANGLE_W+1)'(slew_next);
	assign ad_snap     = (ANGLE_W+1)'(diff_snap[ANGLE_W] ? -diff_snap : diff_snap);
	assign expire_diff = env.clock_tick - deadline_q;

	always_comb begin
		n_angle    = angle_q;
		n_target   = target_q;
		n_vel      = vel_q;
		n_deadline = deadline_q;
		n_last     = last_q;
		n_att      = att_q;
		n_mode     = mode_q;
		wr         = 1'b0;
		det        = 1'b0;
		idle_time  = env.clock_tick - last_q;
		if (op.tick) begin
			unique case (mode_q)
				MODE_VELOCITY: begin
					if (!expire_diff[TIME_W-1]) begin
						n_mode = MODE_IDLE;
						n_vel  = '0;
					end else if (vel_next != angle_q) begin
						n_angle  = vel_next;
						n_target = vel_next;
						n_att    = 1'b1;
						n_last   = env.clock_tick;
						wr       = 1'b1;
					end
				end
				MODE_TARGET: begin
					if (slew_next != angle_q) begin
						n_angle = slew_next;
						n_att   = 1'b1;
						n_last  = env.clock_tick;
						wr      = 1'b1;
					end
					if (ad_snap < (ANGLE_W+1)'(SNAP_MDEG)) begin
						n_angle = target_q;
						n_mode  = MODE_IDLE;
					end
				end
				default: begin
				end
			endcase
			idle_time = env.clock_tick - n_last;
			if (n_att && env.sleep_lim != '0 && n_mode == MODE_IDLE &&
					idle_time >= TIME_W'(env.sleep_lim)) begin
				n_att = 1'b0;
				det   = 1'b1;
			end
		end else if (op.cancel_vel) begin
			if (mode_q != MODE_TARGET) begin
				n_mode = MODE_IDLE;
			end
			n_vel      = '0;
			n_deadline = '0;
			if (op.set_angle) begin
				n_att    = 1'b1;
				n_last   = env.clock_now;
				n_target = ANGLE_W'(op.value);
				if (env.silent_zero) begin
					n_angle = ANGLE_W'(op.value);
					n_mode  = MODE_IDLE;
					wr      = 1'b1;
				end else begin
					n_mode = MODE_TARGET;
				end
			end
		end else if (op.set_vel) begin
			n_att      = 1'b1;
			n_last     = env.clock_now;
			n_vel      = op.value;
			n_deadline = env.deadline_new;
			n_mode     = (op.value == '0) ? MODE_IDLE : MODE_VELOCITY;
		end
	end

	// keep velocity * dt ready for the next tick
	assign vel_src = advance ? n_vel : vel_q;
	assign prod_d  = PROD_W'(vel_src) * PROD_W'($signed({1'b0, env.dt_next}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q    <= '0;
			target_q   <= '0;
			vel_q      <= '0;
			deadline_q <= '0;
			last_q     <= '0;
			att_q      <= 1'b1;
			mode_q     <= MODE_IDLE;
			prod_q     <= '0;
		end else begin
			prod_q <= prod_d;
			if (advance) begin
				angle_q    <= n_angle;
				target_q   <= n_target;
				vel_q      <= n_vel;
				deadline_q <= n_deadline;
				last_q     <= n_last;
				att_q      <= n_att;
				mode_q     <= n_mode;
			end
		end
	end

	assign res.angle    = n_angle;
	assign res.attached = n_att;
	assign res.write    = wr;
	assign res.detach   = det;

endmodule

// File: rtl/tasc_checker.sv
// ----------------------------------------------------------------------------
// Servo controller port checker
// Watches the top-level ports for flow control and result consistency.
// ----------------------------------------------------------------------------
module tasc_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_ready,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic signed [tasc_pkg::ANGLE_W-1:0]  yaw_angle,
	input logic signed [tasc_pkg::ANGLE_W-1:0]  pitch_angle,
	input logic                                 yaw_attached,
	input logic                                 pitch_attached,
	input logic                                 yaw_write,
	input logic                                 pitch_write,
	input logic                                 yaw_detach,
	input logic                                 pitch_detach
);
	import tasc_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(yaw_angle) &&
		$stable(pitch_angle))
		else $error("result changed while stalled");

	// input only stalls behind a stalled result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	// a detach or a position write agrees with the reported attach state
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!yaw_detach || !yaw_attached) && (!pitch_detach || !pitch_attached) &&
		(!yaw_write || yaw_attached) && (!pitch_write || pitch_attached))
		else $error("write/detach flags inconsistent with attach state");

	// a detached axis cannot also be written in the same result
	a_detach_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(yaw_detach && yaw_write) && !(pitch_detach && pitch_write))
		else $error("axis written and detached together");

	// angles stay inside the mechanical limits
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> yaw_angle >= -ANGLE_LIMIT && yaw_angle <= ANGLE_LIMIT &&
		pitch_angle >= -ANGLE_LIMIT && pitch_angle <= ANGLE_LIMIT)
		else $error("angle out of range");

endmodule

bind two_axis_servo_motion_controller tasc_checker u_tasc_checker (.*);
